@@ design/slcl_pkg.sv @@
// ----------------------------------------------------------------------------
// slcl_pkg: shared types and helpers for source line and comment lint
// Lexer codes, report kinds, byte codes, result record and saturating math.
// ----------------------------------------------------------------------------
package slcl_pkg;

    localparam int COLUMN_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int TAB_STOP    = 8;
    localparam int TAB_BITS    = $clog2(TAB_STOP);
    localparam int BAD_BITS    = 16;
    localparam int LINE_W      = 24;
    localparam int OVER_W      = 16;
    localparam int LIMIT_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
    localparam int OUT_TDATA_W = 112;

    localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 16'd80;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_KIND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNPRINT_OK = 2'd2;

    // file kinds
    localparam logic [1:0] FK_OTHER  = 2'd0;
    localparam logic [1:0] FK_C      = 2'd1;
    localparam logic [1:0] FK_CXX    = 2'd2;
    localparam logic [1:0] FK_HEADER = 2'd3;

    // input commands
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    // byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [3:0] {
        LX_NORMAL = 4'd0,
        LX_DQ     = 4'd1,
        LX_DQ_ESC = 4'd2,
        LX_SQ     = 4'd3,
        LX_SQ_ESC = 4'd4,
        LX_SLASH  = 4'd5,
        LX_CXX    = 4'd6,
        LX_CCOM   = 4'd7,
        LX_CBEGIN = 4'd8,
        LX_CDOX   = 4'd9,
        LX_CSTAR  = 4'd10
    } t_lex;

    typedef enum logic [1:0] {
        RK_LINE     = 2'd0,
        RK_CXX_IN_C = 2'd1,
        RK_C_IN_CXX = 2'd2,
        RK_SUMMARY  = 2'd3
    } t_rpt;

    typedef struct packed {
        logic c;
        logic cxx;
        logic hdr;
    } t_kinds;

    typedef struct packed {
        t_lex   state;
        t_kinds kinds;
        logic   rpt;
        t_rpt   rpt_kind;
    } t_lex_res;

    typedef struct packed {
        t_rpt                kind;
        logic [LINE_W-1:0]   line;
        logic [BAD_BITS-1:0] bad;
        logic                badf;
        logic                trail;
        logic [OVER_W-1:0]   over;
        logic                miss;
        logic [LINE_W-1:0]   blank;
        logic                dos;
        logic                bin;
        logic [LINE_W-1:0]   err;
        logic                last;
    } t_result;

    function automatic t_kinds kinds_of(input logic [1:0] fk);
        t_kinds k;
        k.c   = (fk == FK_C);
        k.cxx = (fk == FK_CXX);
        k.hdr = (fk == FK_HEADER);
        return k;
    endfunction

    // saturating add of a small amount to a count
    function automatic logic [COUNT_BITS-1:0] cnt_add(input logic [COUNT_BITS-1:0] v,
                                                      input logic [2:0] k);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS + 1)'(k);
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] v);
        logic [COLUMN_BITS:0] s;
        s = {1'b0, v} + (COLUMN_BITS + 1)'(1);
        return s[COLUMN_BITS] ? '1 : s[COLUMN_BITS-1:0];
    endfunction

    // advance to the next tab stop
    function automatic logic [COLUMN_BITS-1:0] col_tab(input logic [COLUMN_BITS-1:0] v);
        logic [COLUMN_BITS:0] s;
        s = {1'b0, v} + (COLUMN_BITS + 1)'(TAB_STOP);
        s[TAB_BITS-1:0] = '0;
        return s[COLUMN_BITS] ? '1 : s[COLUMN_BITS-1:0];
    endfunction

    function automatic logic [BAD_BITS-1:0] bad_inc(input logic [BAD_BITS-1:0] v);
        return (v == '1) ? v : v + BAD_BITS'(1);
    endfunction

    // clamp a count into a 24-bit report field
    function automatic logic [LINE_W-1:0] to_field(input logic [COUNT_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'({LINE_W{1'b1}})) ? '1 : w[LINE_W-1:0];
    endfunction

endpackage

@@ design/slcl_lex.sv @@
// ----------------------------------------------------------------------------
// slcl_lex: comment and string lexer
// Next lexer state, file kind update and comment-style violation flag.
// ----------------------------------------------------------------------------
module slcl_lex (
    input  slcl_pkg::t_lex     i_state,
    input  slcl_pkg::t_kinds   i_kinds,
    input  logic [7:0]         i_byte,
    input  logic               i_en,
    output slcl_pkg::t_lex_res o_res
);

    slcl_pkg::t_kinds k;
    logic             plain;

    always_comb begin
        o_res.state    = i_state;
        o_res.rpt      = 1'b0;
        o_res.rpt_kind = slcl_pkg::RK_CXX_IN_C;
        k              = i_kinds;
        plain          = 1'b0;
        if (i_en && (i_kinds.c || i_kinds.cxx || i_kinds.hdr)) begin
            unique case (i_state)
                slcl_pkg::LX_SLASH: begin
                    if (i_byte == slcl_pkg::CH_SLASH) begin
                        o_res.state = slcl_pkg::LX_CXX;
                        if (k.hdr && !k.cxx) begin
                            k.cxx = 1'b1;
                        end
                        if (k.c) begin
                            o_res.rpt      = 1'b1;
                            o_res.rpt_kind = slcl_pkg::RK_CXX_IN_C;
                        end
                    end else if (i_byte == slcl_pkg::CH_STAR) begin
                        o_res.state = slcl_pkg::LX_CBEGIN;
                    end else begin
                        o_res.state = slcl_pkg::LX_NORMAL;
                    end
                end
                slcl_pkg::LX_DQ: begin
                    if (i_byte == slcl_pkg::CH_BSL) begin
                        o_res.state = slcl_pkg::LX_DQ_ESC;
                    end else if (i_byte == slcl_pkg::CH_DQ || i_byte == slcl_pkg::CH_LF) begin
                        o_res.state = slcl_pkg::LX_NORMAL;
                    end
                end
                slcl_pkg::LX_DQ_ESC: begin
                    o_res.state = slcl_pkg::LX_DQ;
                end
                slcl_pkg::LX_SQ: begin
                    if (i_byte == slcl_pkg::CH_BSL) begin
                        o_res.state = slcl_pkg::LX_SQ_ESC;
                    end else if (i_byte == slcl_pkg::CH_SQ || i_byte == slcl_pkg::CH_LF) begin
                        o_res.state = slcl_pkg::LX_NORMAL;
                    end
                end
                slcl_pkg::LX_SQ_ESC: begin
                    o_res.state = slcl_pkg::LX_SQ;
                end
                slcl_pkg::LX_CXX: begin
                    if (i_byte == slcl_pkg::CH_LF) begin
                        o_res.state = slcl_pkg::LX_NORMAL;
                    end
                end
                slcl_pkg::LX_CBEGIN: begin
                    if (i_byte == slcl_pkg::CH_STAR) begin
                        o_res.state = slcl_pkg::LX_CDOX;
                    end else begin
                        plain       = 1'b1;
                        o_res.state = slcl_pkg::LX_CCOM;
                    end
                end
                slcl_pkg::LX_CDOX: begin
                    if (i_byte == slcl_pkg::CH_SLASH) begin
                        plain       = 1'b1;
                        o_res.state = slcl_pkg::LX_NORMAL;
                    end else if (i_byte == slcl_pkg::CH_STAR) begin
                        plain       = 1'b1;
                        o_res.state = slcl_pkg::LX_CSTAR;
                    end else begin
                        o_res.state = slcl_pkg::LX_CSTAR;
                    end
                end
                slcl_pkg::LX_CCOM: begin
                    if (i_byte == slcl_pkg::CH_STAR) begin
                        o_res.state = slcl_pkg::LX_CSTAR;
                    end
                end
                slcl_pkg::LX_CSTAR: begin
                    if (i_byte == slcl_pkg::CH_SLASH) begin
                        o_res.state = slcl_pkg::LX_NORMAL;
                    end else if (i_byte != slcl_pkg::CH_STAR) begin
                        o_res.state = slcl_pkg::LX_CCOM;
                    end
                end
                default: begin
                    if (i_byte == slcl_pkg::CH_SLASH) begin
                        o_res.state = slcl_pkg::LX_SLASH;
                    end else if (i_byte == slcl_pkg::CH_SQ) begin
                        o_res.state = slcl_pkg::LX_SQ;
                    end else if (i_byte == slcl_pkg::CH_DQ) begin
                        o_res.state = slcl_pkg::LX_DQ;
                    end else begin
                        o_res.state = slcl_pkg::LX_NORMAL;
                    end
                end
            endcase
            // a plain C comment turns a header into C, and is flagged where the C++ kind is set
            if (plain) begin
                if (k.hdr && !k.c) begin
                    k.hdr = 1'b0;
                    k.c   = 1'b1;
                end
                if (k.cxx) begin
                    o_res.rpt      = 1'b1;
                    o_res.rpt_kind = slcl_pkg::RK_C_IN_CXX;
                end
            end
        end
        o_res.kinds = k;
    end

endmodule

@@ design/slcl_outq.sv @@
// ----------------------------------------------------------------------------
// slcl_outq: result queue
// Small FIFO taking up to two results per cycle and giving one per cycle when popped.
// ----------------------------------------------------------------------------
module slcl_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  slcl_pkg::t_result i_push0,
    input  slcl_pkg::t_result i_push1,
    output logic              o_room2,
    output logic              o_valid,
    output slcl_pkg::t_result o_head,
    input  logic              i_pop
);

    slcl_pkg::t_result                  r_mem [slcl_pkg::OUTQ_DEPTH];
    logic [slcl_pkg::OUTQ_PTR_W-1:0]    r_wp;
    logic [slcl_pkg::OUTQ_PTR_W-1:0]    r_rp;
    logic [slcl_pkg::OUTQ_CNT_W-1:0]    r_count;
    logic [slcl_pkg::OUTQ_CNT_W-1:0]    n_count;
    logic                               pop;
    logic [slcl_pkg::OUTQ_PTR_W-1:0]    wp1;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_room2 = (r_count <= slcl_pkg::OUTQ_CNT_W'(slcl_pkg::OUTQ_DEPTH - 2));
    assign wp1     = r_wp + slcl_pkg::OUTQ_PTR_W'(1);
    assign n_count = r_count + slcl_pkg::OUTQ_CNT_W'(i_push_cnt)
                     - slcl_pkg::OUTQ_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp1] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + slcl_pkg::OUTQ_PTR_W'(i_push_cnt);
            r_rp    <= r_rp + slcl_pkg::OUTQ_PTR_W'(pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> (({1'b0, r_count} + 4'(i_push_cnt))
                                  <= 4'(slcl_pkg::OUTQ_DEPTH)))
        else $error("result queue overflow");

endmodule

@@ design/source_line_and_comment_lint.sv @@
// ----------------------------------------------------------------------------
// source_line_and_comment_lint: per-byte source text checker
// Each result is written into the result queue at its byte transfer and is shown on the master side from there.
// Throughput: one byte per cycle; an item with two results gives them one after the other,
//   and the 4-entry result queue stalls input when nearly full.
// Reset (synchronous, active low): registers to defaults, lexer and counters
//   cleared, result queue emptied; no clearing pass.
// ----------------------------------------------------------------------------
module source_line_and_comment_lint (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave side
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [7:0]                           i_s_tdata,   // [7:0] text_byte
    input  logic                                 i_s_tuser,   // [0] command
    // master side
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [23:0] line_no, [39:24] bad_char_count, [40] bad_char_flag,
    // [41] trailing_space, [57:42] over_by, [58] missing_newline,
    // [82:59] blank_tail, [83] dos_seen, [84] binary_seen,
    // [108:85] error_total, [111:109] zero
    output logic [slcl_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic [1:0]                           o_m_tuser,   // [1:0] report_kind
    output logic                                 o_m_tlast,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [slcl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [slcl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration
    logic [slcl_pkg::LIMIT_W-1:0]     r_line_limit;
    logic [1:0]                       r_file_kind;
    logic                             r_unprint_ok;

    // per-file scan state
    slcl_pkg::t_lex                   r_lex;
    slcl_pkg::t_kinds                 r_kinds;
    logic [slcl_pkg::COLUMN_BITS-1:0] r_column;
    logic [slcl_pkg::BAD_BITS-1:0]    r_bad;
    logic                             r_space_end;
    logic                             r_line_space;
    logic                             r_cr;
    logic [slcl_pkg::COUNT_BITS-1:0]  r_lines;
    logic [slcl_pkg::COUNT_BITS-1:0]  r_blank;
    logic [slcl_pkg::COUNT_BITS-1:0]  r_errors;
    logic                             r_dos;
    logic                             r_bin;

    slcl_pkg::t_lex                   n_lex;
    slcl_pkg::t_kinds                 n_kinds;
    logic [slcl_pkg::COLUMN_BITS-1:0] n_column;
    logic [slcl_pkg::BAD_BITS-1:0]    n_bad;
    logic                             n_space_end;
    logic                             n_line_space;
    logic                             n_cr;
    logic [slcl_pkg::COUNT_BITS-1:0]  n_lines;
    logic [slcl_pkg::COUNT_BITS-1:0]  n_blank;
    logic [slcl_pkg::COUNT_BITS-1:0]  n_errors;
    logic                             n_dos;
    logic                             n_bin;

    logic                             s_accept;
    logic                             cfg_wr;
    logic [7:0]                       in_byte;
    logic                             is_eof;
    logic                             lex_en;
    slcl_pkg::t_lex_res               lx;

    logic                             room2;
    logic [1:0]                       push_cnt;
    slcl_pkg::t_result                push0;
    slcl_pkg::t_result                push1;
    slcl_pkg::t_result                head;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = room2;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign in_byte     = i_s_tdata;
    assign is_eof      = (i_s_tuser == slcl_pkg::CMD_EOF);

    // a held CR followed by LF is a DOS line end and never reaches the lexer
    assign lex_en = !is_eof && !(r_cr && in_byte == slcl_pkg::CH_LF);

    slcl_lex u_lex (
        .i_state (r_lex),
        .i_kinds (r_kinds),
        .i_byte  (in_byte),
        .i_en    (lex_en),
        .o_res   (lx)
    );

    // ------------------------------------------------------------------
    // One-pass step: state update and up to two results per item
    // ------------------------------------------------------------------
    slcl_pkg::t_result cmt_r;
    slcl_pkg::t_result line_r;
    slcl_pkg::t_result sum_r;
    logic              do_end;
    logic              miss;
    logic              badf;
    logic              over;
    logic [32:0]       col_w;
    logic [32:0]       lim_w;
    logic [32:0]       diff_w;

    always_comb begin
        n_lex        = r_lex;
        n_kinds      = r_kinds;
        n_column     = r_column;
        n_bad        = r_bad;
        n_space_end  = r_space_end;
        n_line_space = r_line_space;
        n_cr         = r_cr;
        n_lines      = r_lines;
        n_blank      = r_blank;
        n_errors     = r_errors;
        n_dos        = r_dos;
        n_bin        = r_bin;
        cmt_r        = '0;
        line_r       = '0;
        sum_r        = '0;
        do_end       = 1'b0;
        miss         = 1'b0;
        badf         = 1'b0;
        over         = 1'b0;
        col_w        = '0;
        lim_w        = '0;
        diff_w       = '0;

        if (!is_eof) begin
            if (r_cr && in_byte == slcl_pkg::CH_LF) begin
                n_cr   = 1'b0;
                n_dos  = 1'b1;
                do_end = 1'b1;
            end else begin
                // a stray CR counts as one unprintable trailing column
                if (r_cr) begin
                    n_cr        = 1'b0;
                    n_bad       = slcl_pkg::bad_inc(n_bad);
                    n_column    = slcl_pkg::col_inc(n_column);
                    n_space_end = 1'b1;
                end
                n_lex   = lx.state;
                n_kinds = lx.kinds;
                if (lx.rpt) begin
                    n_errors   = slcl_pkg::cnt_add(n_errors, 3'd1);
                    cmt_r.kind = lx.rpt_kind;
                    cmt_r.line = slcl_pkg::to_field(slcl_pkg::cnt_add(r_lines, 3'd1));
                    cmt_r.err  = slcl_pkg::to_field(n_errors);
                end
                unique case (in_byte)
                    slcl_pkg::CH_FF: begin
                        n_column = slcl_pkg::col_inc(n_column);
                    end
                    slcl_pkg::CH_CR: begin
                        n_cr = 1'b1;
                    end
                    slcl_pkg::CH_LF: begin
                        do_end = 1'b1;
                    end
                    slcl_pkg::CH_TAB: begin
                        n_column     = slcl_pkg::col_tab(n_column);
                        n_space_end  = 1'b1;
                        n_line_space = 1'b1;
                    end
                    slcl_pkg::CH_SPACE: begin
                        n_column     = slcl_pkg::col_inc(n_column);
                        n_space_end  = 1'b1;
                        n_line_space = 1'b1;
                    end
                    default: begin
                        if (in_byte == slcl_pkg::CH_NUL) begin
                            n_bin = 1'b1;
                        end
                        if (in_byte < slcl_pkg::CH_SPACE || in_byte > slcl_pkg::CH_TILDE) begin
                            n_bad = slcl_pkg::bad_inc(n_bad);
                        end
                        n_column    = slcl_pkg::col_inc(n_column);
                        n_space_end = 1'b0;
                    end
                endcase
            end
        end else begin
            // end of file: held CR is unprintable but not trailing space
            if (r_cr) begin
                n_cr     = 1'b0;
                n_bad    = slcl_pkg::bad_inc(n_bad);
                n_column = slcl_pkg::col_inc(n_column);
            end
            if (n_column != '0) begin
                do_end = 1'b1;
                miss   = 1'b1;
            end
        end

        // line report
        if (do_end) begin
            col_w  = 33'(n_column);
            lim_w  = 33'(r_line_limit);
            diff_w = col_w - lim_w;
            badf   = (n_bad != '0) && !r_unprint_ok;
            over   = (col_w > lim_w) && n_line_space;
            n_errors = slcl_pkg::cnt_add(n_errors, 3'(miss) + 3'(badf)
                                         + 3'(n_space_end) + 3'(over));
            n_blank  = (n_column != '0) ? '0 : slcl_pkg::cnt_add(n_blank, 3'd1);
            n_lines  = slcl_pkg::cnt_add(n_lines, 3'd1);
            line_r.kind  = slcl_pkg::RK_LINE;
            line_r.line  = slcl_pkg::to_field(n_lines);
            line_r.bad   = n_bad;
            line_r.badf  = badf;
            line_r.trail = n_space_end;
            if (over) begin
                line_r.over = (diff_w > 33'({slcl_pkg::OVER_W{1'b1}})) ?
                              '1 : diff_w[slcl_pkg::OVER_W-1:0];
            end
            line_r.miss  = miss;
            line_r.err   = slcl_pkg::to_field(n_errors);
            n_column     = '0;
            n_bad        = '0;
            n_space_end  = 1'b0;
            n_line_space = 1'b0;
        end

        // file summary, then clear all scan state for the next file
        if (is_eof) begin
            n_errors = slcl_pkg::cnt_add(n_errors, 3'(n_dos) + 3'(n_blank != '0)
                                         + 3'(n_bin));
            sum_r.kind  = slcl_pkg::RK_SUMMARY;
            sum_r.line  = (n_lines != '0) ? slcl_pkg::to_field(n_lines)
                                          : slcl_pkg::LINE_W'(1);
            sum_r.blank = slcl_pkg::to_field(n_blank);
            sum_r.dos   = n_dos;
            sum_r.bin   = n_bin;
            sum_r.err   = slcl_pkg::to_field(n_errors);
            n_lex        = slcl_pkg::LX_NORMAL;
            n_kinds      = slcl_pkg::kinds_of(r_file_kind);
            n_column     = '0;
            n_bad        = '0;
            n_space_end  = 1'b0;
            n_line_space = 1'b0;
            n_cr         = 1'b0;
            n_lines      = '0;
            n_blank      = '0;
            n_errors     = '0;
            n_dos        = 1'b0;
            n_bin        = 1'b0;
        end

        // order results: comment report, line report, summary
        push_cnt = s_accept ? (2'(lx.rpt && !is_eof) + 2'(do_end) + 2'(is_eof)) : 2'd0;
        if (lx.rpt && !is_eof) begin
            push0 = cmt_r;
            push1 = line_r;
        end else if (do_end) begin
            push0 = line_r;
            push1 = sum_r;
        end else begin
            push0 = sum_r;
            push1 = sum_r;
        end
        // mark the final result of this item
        if (push_cnt == 2'd2) begin
            push1.last = 1'b1;
        end else begin
            push0.last = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // State and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= slcl_pkg::LINE_LIMIT_RESET;
            r_file_kind  <= slcl_pkg::FK_OTHER;
            r_unprint_ok <= 1'b0;
            r_lex        <= slcl_pkg::LX_NORMAL;
            r_kinds      <= slcl_pkg::kinds_of(slcl_pkg::FK_OTHER);
            r_column     <= '0;
            r_bad        <= '0;
            r_space_end  <= 1'b0;
            r_line_space <= 1'b0;
            r_cr         <= 1'b0;
            r_lines      <= '0;
            r_blank      <= '0;
            r_errors     <= '0;
            r_dos        <= 1'b0;
            r_bin        <= 1'b0;
        end else begin
            if (s_accept) begin
                r_lex        <= n_lex;
                r_kinds      <= n_kinds;
                r_column     <= n_column;
                r_bad        <= n_bad;
                r_space_end  <= n_space_end;
                r_line_space <= n_line_space;
                r_cr         <= n_cr;
                r_lines      <= n_lines;
                r_blank      <= n_blank;
                r_errors     <= n_errors;
                r_dos        <= n_dos;
                r_bin        <= n_bin;
            end
            // writes to file_kind reload the kind bits at once
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    slcl_pkg::CFG_LINE_LIMIT: begin
                        r_line_limit <= i_cfg_data[slcl_pkg::LIMIT_W-1:0];
                    end
                    slcl_pkg::CFG_FILE_KIND: begin
                        r_file_kind <= i_cfg_data[1:0];
                        r_kinds     <= slcl_pkg::kinds_of(i_cfg_data[1:0]);
                    end
                    slcl_pkg::CFG_UNPRINT_OK: begin
                        r_unprint_ok <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue and master side
    // ------------------------------------------------------------------
    slcl_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (push0),
        .i_push1    (push1),
        .o_room2    (room2),
        .o_valid    (o_m_tvalid),
        .o_head     (head),
        .i_pop      (i_m_tready)
    );

    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;
    assign o_m_tdata = {3'b000, head.err, head.bin, head.dos, head.blank, head.miss,
                        head.over, head.trail, head.badf, head.bad, head.line};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == slcl_pkg::RK_SUMMARY) |-> o_m_tlast)
        else $error("file summary not marked last");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && is_eof) |=> (r_errors == '0 && r_lines == '0 && !r_cr))
        else $error("state not cleared after end of file");

    a_line_fields_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != slcl_pkg::RK_LINE) |->
            (head.bad == '0 && head.over == '0 && !head.miss))
        else $error("line fields set on a non-line report");

endmodule

@@ test/source_line_and_comment_lint_tb.sv @@
// ----------------------------------------------------------------------------
// source_line_and_comment_lint_tb: self-checking bench for the source lint
// Drives source text bytes and end-of-file commands into the slave stream, and
// predicts every line report, comment report and file summary with its own
// copy of the lexer and line counters. Each transfer on the master stream is
// compared against the oldest prediction. Short directed files come first,
// then random files built from well-formed C tokens mixed with noise, under
// several register settings and with random stalls on both streams.
// ----------------------------------------------------------------------------
module source_line_and_comment_lint_tb;
    import slcl_pkg::*;

    // codes with no name in the package
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata = 8'h00;     // [7:0] text_byte
    logic                   i_s_tuser = CMD_TEXT;  // [0] command
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [23:0] line_no, [39:24] bad_char_count, [40] bad_char_flag,
    // [41] trailing_space, [57:42] over_by, [58] missing_newline,
    // [82:59] blank_tail, [83] dos_seen, [84] binary_seen, [108:85] error_total
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [1:0]             o_m_tuser;             // [1:0] report_kind
    logic                   o_m_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_LINE_LIMIT;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    source_line_and_comment_lint dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Lint predictor: register copies, lexer and per-line / per-file counters
    // ------------------------------------------------------------------------
    logic [15:0] lim_cfg;
    logic [1:0]  kind_cfg;
    logic        unp_ok_cfg;

    t_lex        lx_now;
    logic        is_c, is_cxx, is_hdr;
    logic [15:0] col_pos;
    logic [15:0] unprint_cnt;
    logic        ws_tail;      // line currently ends in white space
    logic        saw_ws;       // line holds some white space
    logic        cr_held;
    logic [23:0] line_cnt, blank_cnt, err_cnt;
    logic        crlf_seen, nul_seen;

    t_result     lint_expect[$];   // predicted reports, oldest first
    int          fail_cnt = 0;
    int          sent_items = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int          rx_stall = 0;
    logic [7:0]  doc_bytes[$];     // random file under construction

    function automatic logic [23:0] inc_cnt(input logic [23:0] v);
        return (v == 24'hFFFFFF) ? v : v + 24'd1;
    endfunction

    function automatic logic [15:0] inc_col(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic load_kinds();
        is_c   = (kind_cfg == FK_C);
        is_cxx = (kind_cfg == FK_CXX);
        is_hdr = (kind_cfg == FK_HEADER);
    endtask

    task automatic clear_file();
        lx_now = LX_NORMAL;
        load_kinds();
        col_pos = '0;
        unprint_cnt = '0;
        ws_tail = 1'b0;
        saw_ws = 1'b0;
        cr_held = 1'b0;
        line_cnt = '0;
        blank_cnt = '0;
        err_cnt = '0;
        crlf_seen = 1'b0;
        nul_seen = 1'b0;
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        case (idx)
            CFG_LINE_LIMIT: lim_cfg = val;
            CFG_FILE_KIND: begin
                kind_cfg = val[1:0];
                load_kinds();
            end
            CFG_UNPRINT_OK: unp_ok_cfg = val[0];
            default: ;
        endcase
    endtask

    task automatic flag_comment(input t_rpt k);
        t_result r;
        err_cnt = inc_cnt(err_cnt);
        r = '0;
        r.kind = k;
        r.line = inc_cnt(line_cnt);
        r.err = err_cnt;
        lint_expect.push_back(r);
    endtask

    // a plain C comment turns a header into C, and is an error in C++
    task automatic note_c_comment();
        if (is_hdr && !is_c) begin
            is_hdr = 1'b0;
            is_c = 1'b1;
        end
        if (is_cxx) flag_comment(RK_C_IN_CXX);
    endtask

    task automatic lex_byte(input logic [7:0] b);
        if (!is_c && !is_cxx && !is_hdr) return;
        case (lx_now)
            LX_SLASH: begin
                if (b == CH_SLASH) begin
                    lx_now = LX_CXX;
                    if (is_hdr) is_cxx = 1'b1;
                    if (is_c) flag_comment(RK_CXX_IN_C);
                end else if (b == CH_STAR) begin
                    lx_now = LX_CBEGIN;
                end else begin
                    lx_now = LX_NORMAL;
                end
            end
            LX_DQ: begin
                if (b == CH_BSL) lx_now = LX_DQ_ESC;
                else if (b == CH_DQ || b == CH_LF) lx_now = LX_NORMAL;
            end
            LX_DQ_ESC: lx_now = LX_DQ;
            LX_SQ: begin
                if (b == CH_BSL) lx_now = LX_SQ_ESC;
                else if (b == CH_SQ || b == CH_LF) lx_now = LX_NORMAL;
            end
            LX_SQ_ESC: lx_now = LX_SQ;
            LX_CXX: if (b == CH_LF) lx_now = LX_NORMAL;
            LX_CBEGIN: begin
                if (b == CH_STAR) begin
                    lx_now = LX_CDOX;
                end else begin
                    note_c_comment();
                    lx_now = LX_CCOM;
                end
            end
            // slash-star-star: a doc comment unless it closes or adds a star
            LX_CDOX: begin
                if (b == CH_SLASH) begin
                    note_c_comment();
                    lx_now = LX_NORMAL;
                end else if (b == CH_STAR) begin
                    note_c_comment();
                    lx_now = LX_CSTAR;
                end else begin
                    lx_now = LX_CSTAR;
                end
            end
            LX_CCOM: if (b == CH_STAR) lx_now = LX_CSTAR;
            LX_CSTAR: begin
                if (b == CH_SLASH) lx_now = LX_NORMAL;
                else if (b != CH_STAR) lx_now = LX_CCOM;
            end
            default: begin
                if (b == CH_SLASH) lx_now = LX_SLASH;
                else if (b == CH_SQ) lx_now = LX_SQ;
                else if (b == CH_DQ) lx_now = LX_DQ;
                else lx_now = LX_NORMAL;
            end
        endcase
    endtask

    task automatic close_line(input bit missing);
        t_result r;
        logic badf, over;
        badf = (unprint_cnt != 0) && !unp_ok_cfg;
        over = (col_pos > lim_cfg) && saw_ws;
        if (missing) err_cnt = inc_cnt(err_cnt);
        if (badf) err_cnt = inc_cnt(err_cnt);
        if (ws_tail) err_cnt = inc_cnt(err_cnt);
        if (over) err_cnt = inc_cnt(err_cnt);
        blank_cnt = (col_pos == 0) ? inc_cnt(blank_cnt) : '0;
        line_cnt = inc_cnt(line_cnt);
        r = '0;
        r.kind = RK_LINE;
        r.line = line_cnt;
        r.bad = unprint_cnt;
        r.badf = badf;
        r.trail = ws_tail;
        r.over = over ? col_pos - lim_cfg : '0;
        r.miss = missing;
        r.err = err_cnt;
        lint_expect.push_back(r);
        col_pos = '0;
        unprint_cnt = '0;
        ws_tail = 1'b0;
        saw_ws = 1'b0;
    endtask

    // advance the predictor by one accepted input transfer
    task automatic predict_item(input logic cmd, input logic [7:0] b);
        t_result r;
        int      n0;
        int      tab_to;
        bit      done;
        n0 = lint_expect.size();
        done = 1'b0;
        if (cmd == CMD_TEXT) begin
            // a held CR either pairs with LF or becomes a stray column
            if (cr_held) begin
                cr_held = 1'b0;
                if (b == CH_LF) begin
                    crlf_seen = 1'b1;
                    close_line(1'b0);
                    done = 1'b1;
                end else begin
                    unprint_cnt = inc_col(unprint_cnt);
                    col_pos = inc_col(col_pos);
                    ws_tail = 1'b1;
                end
            end
            if (!done) begin
                lex_byte(b);
                if (b == CH_FF) begin
                    col_pos = inc_col(col_pos);
                end else if (b == CH_CR) begin
                    cr_held = 1'b1;
                end else if (b == CH_LF) begin
                    close_line(1'b0);
                end else if (b == CH_TAB) begin
                    tab_to = (int'(col_pos) + TAB_STOP) & ~(TAB_STOP - 1);
                    col_pos = (tab_to > 16'hFFFF) ? 16'hFFFF : tab_to[15:0];
                    ws_tail = 1'b1;
                    saw_ws = 1'b1;
                end else if (b == CH_SPACE) begin
                    col_pos = inc_col(col_pos);
                    ws_tail = 1'b1;
                    saw_ws = 1'b1;
                end else begin
                    if (b == CH_NUL) nul_seen = 1'b1;
                    if (b < CH_SPACE || b > CH_TILDE) unprint_cnt = inc_col(unprint_cnt);
                    col_pos = inc_col(col_pos);
                    ws_tail = 1'b0;
                end
            end
        end else begin
            if (cr_held) begin
                cr_held = 1'b0;
                unprint_cnt = inc_col(unprint_cnt);
                col_pos = inc_col(col_pos);
            end
            if (col_pos != 0) close_line(1'b1);
            if (crlf_seen) err_cnt = inc_cnt(err_cnt);
            if (blank_cnt != 0) err_cnt = inc_cnt(err_cnt);
            if (nul_seen) err_cnt = inc_cnt(err_cnt);
            r = '0;
            r.kind = RK_SUMMARY;
            r.line = (line_cnt != 0) ? line_cnt : 24'd1;
            r.blank = blank_cnt;
            r.dos = crlf_seen;
            r.bin = nul_seen;
            r.err = err_cnt;
            lint_expect.push_back(r);
            clear_file();
        end
        // mark the final report of this transfer
        if (lint_expect.size() > n0) begin
            r = lint_expect.pop_back();
            r.last = 1'b1;
            lint_expect.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stream and register drivers
    // ------------------------------------------------------------------------

    // Drive one byte or end-of-file command; valid stays high after the
    // transfer so the next call can follow back to back.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_item(cmd, b);
        sent_items++;
    endtask

    // Drop valid and hold until every predicted report has been taken, then
    // let the block finish any byte that produced no report.
    task automatic drain_reports();
        i_s_tvalid <= 1'b0;
        while (lint_expect.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all registers back to back; upper data bits of the narrow
    // registers carry junk, which the block must ignore.
    task automatic set_config(input logic [15:0] limit_v, input logic [1:0] kind_v,
                              input logic unp_v, input bit poke_spare);
        logic [CFG_IDX_W-1:0]  idx_list[4];
        logic [CFG_DATA_W-1:0] data_list[4];
        int                    nwr;
        int                    i;
        idx_list[0] = CFG_LINE_LIMIT;
        idx_list[1] = CFG_FILE_KIND;
        idx_list[2] = CFG_UNPRINT_OK;
        idx_list[3] = CFG_SPARE;
        data_list[0] = limit_v;
        data_list[1] = {14'($urandom), kind_v};
        data_list[2] = {15'($urandom), unp_v};
        data_list[3] = 16'($urandom);
        nwr = poke_spare ? 4 : 3;
        for (i = 0; i < nwr; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[i];
            i_cfg_data <= data_list[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            apply_config(idx_list[i], data_list[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, none while rx_calm is set
    always @(posedge i_clk) begin
        if (rx_stall != 0) begin
            i_m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            i_m_tready <= 1'b1;
            rx_stall <= rx_calm ? 0 : pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Report checker: sample mid-cycle, where the handshake is settled and the
    // transfer happens at the next rising edge.
    // ------------------------------------------------------------------------
    task automatic show_report(input string tag, input t_result r);
        $write("  %s kind=%0d line=%0d bad=%0d badf=%0b trail=%0b over=%0d",
               tag, r.kind, r.line, r.bad, r.badf, r.trail, r.over);
        $display(" miss=%0b blank=%0d dos=%0b bin=%0b err=%0d last=%0b",
                 r.miss, r.blank, r.dos, r.bin, r.err, r.last);
    endtask

    always @(negedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind  = t_rpt'(o_m_tuser);
            got.line  = o_m_tdata[23:0];
            got.bad   = o_m_tdata[39:24];
            got.badf  = o_m_tdata[40];
            got.trail = o_m_tdata[41];
            got.over  = o_m_tdata[57:42];
            got.miss  = o_m_tdata[58];
            got.blank = o_m_tdata[82:59];
            got.dos   = o_m_tdata[83];
            got.bin   = o_m_tdata[84];
            got.err   = o_m_tdata[108:85];
            got.last  = o_m_tlast;
            if (lint_expect.size() == 0) begin
                if (fail_cnt < 10) begin
                    $display("unexpected report at %0t", $time);
                    show_report("got ", got);
                end
                fail_cnt++;
            end else begin
                want = lint_expect.pop_front();
                if (got.kind !== want.kind || got.line !== want.line ||
                    got.bad !== want.bad || got.badf !== want.badf ||
                    got.trail !== want.trail || got.over !== want.over ||
                    got.miss !== want.miss || got.blank !== want.blank ||
                    got.dos !== want.dos || got.bin !== want.bin ||
                    got.err !== want.err || got.last !== want.last) begin
                    if (fail_cnt < 10) begin
                        $display("report mismatch at %0t", $time);
                        show_report("want", want);
                        show_report("got ", got);
                    end
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed files
    // ------------------------------------------------------------------------

    // C file, limit 2: C++ comment, white space, NUL, a high byte, form feed,
    // stray CR, CR LF, then a blank line and a clean end of file.
    task automatic test_c_file_line_checks();
        logic [7:0] seq[12];
        seq = '{CH_SLASH, CH_SLASH, CH_SPACE, CH_TAB, CH_NUL, 8'hFF,
                CH_FF, CH_CR, 8'h78, CH_CR, CH_LF, CH_LF};
        drain_reports();
        set_config(16'd2, FK_C, 1'b0, 1'b1);
        foreach (seq[i]) send_item(CMD_TEXT, seq[i]);
        send_item(CMD_EOF, 8'hA5);
    endtask

    // Header, limit 0, unprintables allowed: an empty C comment makes it C,
    // a later C++ comment is then flagged; the file ends on a held CR.
    task automatic test_header_kind_switch();
        logic [7:0] seq[7];
        seq = '{CH_SLASH, CH_STAR, CH_STAR, CH_SLASH, CH_SLASH, CH_SLASH, CH_CR};
        drain_reports();
        set_config(16'd0, FK_HEADER, 1'b1, 1'b0);
        foreach (seq[i]) send_item(CMD_TEXT, seq[i]);
        send_item(CMD_EOF, 8'h5A);
    endtask

    // C++ file, largest limit: a doc opener followed by a star is a plain
    // C comment and gets flagged.
    task automatic test_cxx_file_c_comment();
        logic [7:0] seq[6];
        seq = '{CH_SLASH, CH_STAR, CH_STAR, CH_STAR, CH_SLASH, CH_LF};
        drain_reports();
        set_config(16'hFFFF, FK_CXX, 1'b0, 1'b0);
        foreach (seq[i]) send_item(CMD_TEXT, seq[i]);
        send_item(CMD_EOF, 8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Random files
    // ------------------------------------------------------------------------
    task automatic put_word(input int n);
        repeat (n) doc_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));   // a..z
    endtask

    // Append one token: mostly well-formed C lexemes, some noise and breakage
    task automatic put_token();
        case ($urandom_range(0, 15))
            0, 1, 2: put_word($urandom_range(1, 8));
            3: doc_bytes.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
            4, 5: repeat ($urandom_range(1, 3)) doc_bytes.push_back(CH_SPACE);
            6: doc_bytes.push_back(CH_TAB);
            7: begin
                doc_bytes.push_back(CH_DQ);
                put_word($urandom_range(0, 4));
                if ($urandom_range(0, 2) == 0) begin
                    doc_bytes.push_back(CH_BSL);
                    doc_bytes.push_back($urandom_range(0, 1) ? CH_DQ : CH_BSL);
                    put_word($urandom_range(0, 3));
                end
                // leave some strings open
                if ($urandom_range(0, 5) != 0) doc_bytes.push_back(CH_DQ);
            end
            8: begin
                doc_bytes.push_back(CH_SQ);
                if ($urandom_range(0, 2) == 0) begin
                    doc_bytes.push_back(CH_BSL);
                    doc_bytes.push_back(CH_SQ);
                end else begin
                    put_word(1);
                end
                doc_bytes.push_back(CH_SQ);
            end
            9: begin
                doc_bytes.push_back(CH_SLASH);
                doc_bytes.push_back(CH_SLASH);
                put_word($urandom_range(0, 6));
            end
            10: begin
                doc_bytes.push_back(CH_SLASH);
                doc_bytes.push_back(CH_STAR);
                put_word($urandom_range(0, 5));
                if ($urandom_range(0, 2) == 0) begin
                    doc_bytes.push_back(CH_LF);
                    put_word($urandom_range(0, 5));
                end
                if ($urandom_range(0, 3) == 0) doc_bytes.push_back(CH_STAR);
                doc_bytes.push_back(CH_STAR);
                doc_bytes.push_back(CH_SLASH);
            end
            11: begin
                doc_bytes.push_back(CH_SLASH);
                doc_bytes.push_back(CH_STAR);
                doc_bytes.push_back(CH_STAR);
                if ($urandom_range(0, 2) != 0) put_word($urandom_range(1, 5));
                else if ($urandom_range(0, 1)) doc_bytes.push_back(CH_STAR);
                doc_bytes.push_back(CH_STAR);
                doc_bytes.push_back(CH_SLASH);
            end
            12: doc_bytes.push_back(CH_FF);
            13: doc_bytes.push_back(8'($urandom_range(0, 255)));
            14: doc_bytes.push_back(CH_CR);
            default: doc_bytes.push_back(CH_SLASH);
        endcase
    endtask

    task automatic build_file();
        int nlines, ntok, l;
        doc_bytes.delete();
        nlines = $urandom_range(1, 10);
        for (l = 0; l < nlines; l++) begin
            ntok = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
            repeat (ntok) put_token();
            // last line may lack its newline
            if (l != nlines - 1 || $urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 3) == 0) doc_bytes.push_back(CH_CR);
                doc_bytes.push_back(CH_LF);
            end
        end
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) doc_bytes.push_back(CH_LF);
    endtask

    task automatic play_file(input bit force_hold);
        int i;
        for (i = 0; i < doc_bytes.size(); i++) begin
            // hold the sender until the block has emptied its output
            if ((force_hold && i == doc_bytes.size() / 2) || $urandom_range(0, 299) == 0)
                drain_reports();
            send_item(CMD_TEXT, doc_bytes[i]);
        end
        send_item(CMD_EOF, 8'($urandom));
    endtask

    task automatic test_random_files();
        int          goal, phase;
        logic [15:0] lim;
        logic [1:0]  kind;
        logic        unp;
        goal = sent_items + 1300;
        phase = 0;
        while (sent_items < goal) begin
            drain_reports();
            case (phase)
                0: begin lim = 16'd0;    kind = FK_HEADER; unp = 1'b0; end
                1: begin lim = 16'hFFFF; kind = FK_CXX;    unp = 1'b1; end
                2: begin lim = 16'd80;   kind = FK_C;      unp = 1'b0; end
                3: begin lim = 16'd20;   kind = FK_OTHER;  unp = 1'b1; end
                default: begin
                    lim = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 60))
                                                    : 16'($urandom);
                    kind = 2'($urandom);
                    unp = 1'($urandom);
                end
            endcase
            set_config(lim, kind, unp, 1'b0);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                build_file();
                play_file(phase == 0);
            end
            phase++;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int spin;
        lim_cfg = LINE_LIMIT_RESET;
        kind_cfg = FK_OTHER;
        unp_ok_cfg = 1'b0;
        clear_file();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_c_file_line_checks();
        test_header_kind_switch();
        test_cxx_file_c_comment();
        test_random_files();

        // wait out the remaining reports, bounded
        i_s_tvalid <= 1'b0;
        for (spin = 0; spin < 100000 && lint_expect.size() != 0; spin++) @(posedge i_clk);
        if (lint_expect.size() != 0) begin
            $display("%0d predicted reports never arrived", lint_expect.size());
            fail_cnt++;
        end
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("source_line_and_comment_lint_tb: clean");
        end else begin
            $display("source_line_and_comment_lint_tb: errors");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #20000000;
        $display("source_line_and_comment_lint_tb: errors");
        $finish;
    end

endmodule
